### design/ao0cm_pkg.sv
// Package: shared types and constants of the adaptive order-0 cost model
`timescale 1ns / 1ps
package ao0cm_pkg;

    localparam int MAX_SYMBOLS_DEF = 1024;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int SYM_W           = 10;
    localparam int CNT_W           = 16;
    localparam int COST_W          = 21;
    localparam int ACC_W           = 48;
    localparam int ALPHA_W         = 11;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RESCALE_LIMIT = 1'b1;

    localparam logic [ALPHA_W-1:0] ALPHABET_RESET = 11'd256;
    localparam logic [CNT_W-1:0]   LIMIT_RESET    = 16'd60000;
    localparam logic [CNT_W-1:0]   LIMIT_CAP      = 16'd65534;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             start_sequence;
    } in_item_t;

    typedef struct packed {
        logic [COST_W-1:0] symbol_cost;
        logic [ACC_W-1:0]  total_cost;
    } out_item_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             start_sequence;
    } job_t;

endpackage

### design/ao0cm_ram.sv
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
module ao0cm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read first: a write returns the old contents, read registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### design/ao0cm_front.sv
// Front end: input queue of two transactions
`timescale 1ns / 1ps
module ao0cm_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  ao0cm_pkg::in_item_t  in_item,
    output logic                 job_valid,
    input  logic                 job_take,
    output ao0cm_pkg::job_t      job
);

    ao0cm_pkg::job_t slot_reg [2];
    logic            wptr_reg, rptr_reg;
    logic [1:0]      cnt_reg;
    logic            do_push, do_pop;

    assign full      = cnt_reg[1];
    assign job_valid = cnt_reg != 2'd0;
    assign job       = slot_reg[rptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = job_take && job_valid;

    // store the incoming transaction
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg].symbol         <= in_item.symbol;
            slot_reg[wptr_reg].start_sequence <= in_item.start_sequence;
        end
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (do_pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

### design/ao0cm_log.sv
// Iterative fixed-point log2 unit, one squaring per fraction bit
`timescale 1ns / 1ps
module ao0cm_log #(
    parameter int FRAC_BITS = ao0cm_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [ao0cm_pkg::CNT_W-1:0]     x,
    output logic                            done,
    output logic [FRAC_BITS+3:0]            result
);

    localparam int YW = 64;
    localparam int IW = $clog2(FRAC_BITS + 1);

    // each iteration forms three 32x32 partial products, then sums them into the square
    logic [YW-1:0]      y_reg;
    logic [FRAC_BITS+3:0] r_reg;
    logic [IW-1:0]      left_reg;
    logic [1:0]         ph_reg;
    logic               busy_reg;
    logic [63:0]        p0_reg, p1_reg, p3_reg;
    logic [3:0]         e;
    logic [127:0]       sq;
    logic [YW-1:0]      ysq;

    always_comb
    begin
        e = 4'd0;
        for (int k = 0; k < ao0cm_pkg::CNT_W; k++)
        begin
            if (x[k])
            begin
                e = 4'(k);
            end
        end
    end

    assign sq  = {p3_reg, 64'd0} + {31'd0, p1_reg, 33'd0} + {64'd0, p0_reg};
    assign ysq = sq[62 +: YW];
    assign done   = busy_reg && left_reg == '0;
    assign result = r_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            y_reg  <= {48'd0, x} << (7'd62 - {3'd0, e});
            r_reg  <= (FRAC_BITS+4)'({e}) << FRAC_BITS;
        end
        else if (busy_reg && left_reg != '0)
        begin
            unique case (ph_reg)
                2'd0: p0_reg <= y_reg[31:0] * y_reg[31:0];
                2'd1: p1_reg <= y_reg[31:0] * y_reg[63:32];
                2'd2: p3_reg <= y_reg[63:32] * y_reg[63:32];
                default:
                begin
                    if (ysq[63])
                    begin
                        y_reg <= ysq >> 1;
                        r_reg[left_reg-1'b1] <= 1'b1;
                    end
                    else
                    begin
                        y_reg <= ysq;
                    end
                end
            endcase
        end
    end

    // step the iteration counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            left_reg <= '0;
            ph_reg   <= 2'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            left_reg <= IW'(FRAC_BITS);
            ph_reg   <= 2'd0;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            ph_reg <= ph_reg + 2'd1;
            if (ph_reg == 2'd3)
            begin
                left_reg <= left_reg - 1'b1;
            end
        end
    end

endmodule

### design/ao0cm_back.sv
// Back end: count memory, costing, update, rescale and init sweeps, result register
`timescale 1ns / 1ps
module ao0cm_back #(
    parameter int MAX_SYMBOLS = ao0cm_pkg::MAX_SYMBOLS_DEF,
    parameter int FRAC_BITS   = ao0cm_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               job_valid,
    output logic                               job_take,
    input  ao0cm_pkg::job_t                    job,
    input  logic [ao0cm_pkg::ALPHA_W-1:0]      alphabet_size,
    input  logic [ao0cm_pkg::CNT_W-1:0]        rescale_limit,
    output logic                               empty,
    input  logic                               pop,
    output ao0cm_pkg::out_item_t               out_item
);

    localparam int AW = $clog2(MAX_SYMBOLS);
    localparam int SW = $clog2(MAX_SYMBOLS + 1);
    localparam int LW = FRAC_BITS + 4;

    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b0000000001,
        ST_IDLE   = 10'b0000000010,
        ST_READ   = 10'b0000000100,
        ST_LOGT   = 10'b0000001000,
        ST_LOGC   = 10'b0000010000,
        ST_EMIT   = 10'b0000100000,
        ST_RSRD   = 10'b0001000000,
        ST_RSWR   = 10'b0010000000,
        ST_WAIT   = 10'b0100000000,
        ST_REPL   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0]                 addr_reg;
    logic [SW-1:0]                 active_reg;
    logic [ao0cm_pkg::CNT_W-1:0]   total_reg;
    logic [ao0cm_pkg::CNT_W-1:0]   sum_reg;
    logic [ao0cm_pkg::ACC_W-1:0]   acc_reg;
    logic [LW-1:0]                 lt_reg;
    logic [ao0cm_pkg::SYM_W-1:0]   sym_reg;
    logic [ao0cm_pkg::CNT_W-1:0]   cnt_reg;
    logic                          ovalid_reg;
    logic                          replay_reg;
    ao0cm_pkg::out_item_t          oitem_reg;

    logic                          ram_we;
    logic [AW-1:0]                 ram_addr;
    logic [ao0cm_pkg::CNT_W-1:0]   ram_wdata, ram_rdata;
    logic                          log_start, log_done;
    logic [ao0cm_pkg::CNT_W-1:0]   log_x;
    logic [LW-1:0]                 log_r;
    logic [SW-1:0]                 alpha_clamped;
    logic [ao0cm_pkg::CNT_W-1:0]   limit;
    logic [ao0cm_pkg::CNT_W-1:0]   half;
    logic [LW-1:0]                 cost;
    logic [ao0cm_pkg::ACC_W:0]     acc_sum;
    logic [ao0cm_pkg::CNT_W-1:0]   total_inc;
    logic                          in_range;
    logic                          sym_in_range;

    ao0cm_ram #(.WIDTH(ao0cm_pkg::CNT_W), .DEPTH(MAX_SYMBOLS)) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    ao0cm_log #(.FRAC_BITS(FRAC_BITS)) u_log (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .x      (log_x),
        .done   (log_done),
        .result (log_r)
    );

    // clamp configuration values
    always_comb
    begin
        if (alphabet_size < 11'd2)
            alpha_clamped = SW'(2);
        else if ({21'd0, alphabet_size} > 32'(MAX_SYMBOLS))
            alpha_clamped = SW'(MAX_SYMBOLS);
        else
            alpha_clamped = SW'(alphabet_size);
        limit = (rescale_limit > ao0cm_pkg::LIMIT_CAP) ? ao0cm_pkg::LIMIT_CAP
                                                       : rescale_limit;
    end

    assign in_range     = {{(32-ao0cm_pkg::SYM_W){1'b0}}, job.symbol} < 32'(active_reg);
    assign sym_in_range = {{(32-ao0cm_pkg::SYM_W){1'b0}}, sym_reg} < 32'(active_reg);
    assign half      = 16'((17'(ram_rdata) + 17'd1) >> 1);
    assign cost      = (lt_reg > log_r) ? lt_reg - log_r : '0;
    assign acc_sum   = {1'b0, acc_reg} + (ao0cm_pkg::ACC_W+1)'(cost);
    assign total_inc = total_reg + 16'd1;
    assign empty     = !ovalid_reg;
    assign out_item  = oitem_reg;

    // next state and memory port control
    always_comb
    begin
        state_next = state_reg;
        job_take   = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = addr_reg;
        ram_wdata  = 16'd1;
        log_start  = 1'b0;
        log_x      = total_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                if (addr_reg == AW'(MAX_SYMBOLS - 1))
                    state_next = replay_reg ? ST_REPL : ST_IDLE;
            end
            ST_IDLE:
            begin
                if (job_valid && !ovalid_reg)
                begin
                    job_take = 1'b1;
                    if (job.start_sequence)
                    begin
                        ram_addr   = '0;
                        ram_we     = 1'b1;
                        state_next = ST_CLEAR;
                    end
                    else if (in_range)
                    begin
                        ram_addr   = AW'(job.symbol);
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_REPL:
            begin
                ram_addr = AW'(sym_reg);
                if (sym_in_range)
                    state_next = ST_READ;
                else
                    state_next = ST_IDLE;
            end
            ST_READ:
            begin
                log_start  = 1'b1;
                state_next = ST_LOGT;
            end
            ST_LOGT:
            begin
                log_x = cnt_reg;
                if (log_done)
                begin
                    log_start  = 1'b1;
                    state_next = ST_LOGC;
                end
            end
            ST_LOGC:
            begin
                if (log_done)
                begin
                    ram_addr   = AW'(sym_reg);
                    ram_we     = 1'b1;
                    ram_wdata  = cnt_reg + 16'd1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                ram_addr = '0;
                if (total_reg > limit)
                    state_next = ST_RSRD;
                else
                    state_next = ST_IDLE;
            end
            ST_RSRD:
            begin
                state_next = ST_RSWR;
            end
            ST_RSWR:
            begin
                ram_we    = 1'b1;
                ram_wdata = half;
                if (32'(addr_reg) == 32'(active_reg) - 1)
                    state_next = ST_IDLE;
                else
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                state_next = ST_RSRD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // model state, sweep address and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            addr_reg   <= '0;
            active_reg <= SW'(ao0cm_pkg::ALPHABET_RESET);
            total_reg  <= 16'(ao0cm_pkg::ALPHABET_RESET);
            acc_reg    <= '0;
            ovalid_reg <= 1'b0;
            replay_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop && ovalid_reg)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (addr_reg == AW'(MAX_SYMBOLS - 1))
                    begin
                        addr_reg   <= '0;
                        replay_reg <= 1'b0;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (job_take)
                    begin
                        sym_reg <= job.symbol;
                        if (job.start_sequence)
                        begin
                            active_reg <= alpha_clamped;
                            total_reg  <= 16'(alpha_clamped);
                            acc_reg    <= '0;
                            addr_reg   <= AW'(1);
                            replay_reg <= 1'b1;
                            // the symbol is replayed after the clear sweep
                        end
                        else if (!in_range)
                        begin
                            ovalid_reg <= 1'b1;
                            oitem_reg.symbol_cost <= '0;
                            oitem_reg.total_cost  <= acc_reg;
                        end
                    end
                end
                ST_REPL:
                begin
                    // outside the alphabet: report a zero cost, no update
                    if (!sym_in_range)
                    begin
                        ovalid_reg <= 1'b1;
                        oitem_reg.symbol_cost <= '0;
                        oitem_reg.total_cost  <= acc_reg;
                    end
                end
                ST_READ:
                begin
                    cnt_reg <= ram_rdata;
                end
                ST_LOGT:
                begin
                    if (log_done)
                        lt_reg <= log_r;
                end
                ST_LOGC:
                begin
                    if (log_done)
                    begin
                        acc_reg <= acc_sum[ao0cm_pkg::ACC_W] ? '1
                                   : acc_sum[ao0cm_pkg::ACC_W-1:0];
                        ovalid_reg <= 1'b1;
                        oitem_reg.symbol_cost <= ao0cm_pkg::COST_W'(cost);
                        oitem_reg.total_cost  <= acc_sum[ao0cm_pkg::ACC_W] ? '1
                                                 : acc_sum[ao0cm_pkg::ACC_W-1:0];
                        total_reg <= total_inc;
                    end
                end
                ST_EMIT:
                begin
                    addr_reg <= '0;
                    sum_reg  <= '0;
                end
                ST_RSWR:
                begin
                    if (32'(addr_reg) == 32'(active_reg) - 1)
                    begin
                        total_reg <= sum_reg + half;
                        addr_reg  <= '0;
                    end
                    else
                    begin
                        sum_reg  <= sum_reg + half;
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

### design/adaptive_order0_cost_model_top.sv
// Top level: adaptive order-0 cost model with configuration port
`timescale 1ns / 1ps
//  channel   | handshake        | payload
//  input     | push / full      | in_item  (symbol, start_sequence)
//  result    | pop / empty      | out_item (symbol_cost, total_cost)
//  config    | cfg_valid/ready  | cfg_index, cfg_data
// Each symbol passes through the shared squaring log unit twice, for the total and for
// its count (three partial products and a squaring per fraction bit).
// A rescale reads, halves and writes the count of every active symbol; a start clears all MAX_SYMBOLS counts.
// After reset the whole count memory is cleared before items are taken.
// Input stalls only when the two-entry queue is full; one result waits in its register.
module adaptive_order0_cost_model_top #(
    parameter int MAX_SYMBOLS = ao0cm_pkg::MAX_SYMBOLS_DEF,
    parameter int FRAC_BITS   = ao0cm_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  ao0cm_pkg::in_item_t                 in_item,
    output logic                                empty,
    input  logic                                pop,
    output ao0cm_pkg::out_item_t                out_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ao0cm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ao0cm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic                           job_valid, job_take;
    ao0cm_pkg::job_t                job;
    logic [ao0cm_pkg::ALPHA_W-1:0]  alpha_reg;
    logic [ao0cm_pkg::CNT_W-1:0]    limit_reg;

    assign cfg_ready = 1'b1;

    // write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ao0cm_pkg::ALPHABET_RESET;
            limit_reg <= ao0cm_pkg::LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ao0cm_pkg::REG_ALPHABET_SIZE: alpha_reg <= cfg_data[ao0cm_pkg::ALPHA_W-1:0];
                ao0cm_pkg::REG_RESCALE_LIMIT: limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    ao0cm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .job_valid (job_valid),
        .job_take  (job_take),
        .job       (job)
    );

    ao0cm_back #(.MAX_SYMBOLS(MAX_SYMBOLS), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (job_valid),
        .job_take      (job_take),
        .job           (job),
        .alphabet_size (alpha_reg),
        .rescale_limit (limit_reg),
        .empty         (empty),
        .pop           (pop),
        .out_item      (out_item)
    );

endmodule
